/* rtl/gbn_pkg.sv */
// Shared types, codes and command/status structs for the go-back-N sender window.
// No dependencies; compiled first.
package gbn_pkg;

  localparam int SEQ_W = 4;

  typedef logic [SEQ_W-1:0] seq_t;
  typedef logic [1:0]       cmd_t;
  typedef logic [2:0]       kind_t;
  typedef logic [1:0]       timer_t;
  typedef logic [1:0]       dup_t;

  // input command codes
  localparam cmd_t CMD_SEND    = 2'd0;
  localparam cmd_t CMD_ACK     = 2'd1;
  localparam cmd_t CMD_TIMEOUT = 2'd2;
  localparam cmd_t CMD_UNUSED  = 2'd3;

  // result kinds
  localparam kind_t KIND_REFUSED  = 3'd0;
  localparam kind_t KIND_NEW      = 3'd1;
  localparam kind_t KIND_RETX     = 3'd2;
  localparam kind_t KIND_ACCEPTED = 3'd3;
  localparam kind_t KIND_IGNORED  = 3'd4;
  localparam kind_t KIND_EMPTY    = 3'd5;

  // timer commands
  localparam timer_t TIMER_NONE  = 2'd0;
  localparam timer_t TIMER_START = 2'd1;
  localparam timer_t TIMER_STOP  = 2'd2;

  localparam dup_t DUP_LIMIT   = 2'd3;
  localparam seq_t WINDOW_INIT = 4'd4;

  typedef struct packed {
    kind_t  kind;
    seq_t   seq;
    timer_t timer_action;
    logic   last;
    logic   all_acked;
  } res_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // transaction accepted on the request channel
    logic step;   // load the next retransmit result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic emit;      // accepted command produces a result
    logic more;      // accepted command starts a retransmit run of two or more
    logic run_last;  // next step loads the final result of the run
  } dp_stat_t;

endpackage

/* rtl/gbn_ifs.sv */
// Valid/ready channel interfaces for requests and results.
// Depends on gbn_pkg.
interface gbn_req_if;
  import gbn_pkg::*;
  logic valid;
  logic ready;
  cmd_t command;
  seq_t ack_seq;
  logic ack_valid;
  modport source(output valid, command, ack_seq, ack_valid, input ready);
  modport sink(input valid, command, ack_seq, ack_valid, output ready);
endinterface

interface gbn_res_if;
  import gbn_pkg::*;
  logic   valid;
  logic   ready;
  kind_t  kind;
  seq_t   seq;
  timer_t timer_action;
  logic   last;
  logic   all_acked;
  modport source(output valid, kind, seq, timer_action, last, all_acked, input ready);
  modport sink(input valid, kind, seq, timer_action, last, all_acked, output ready);
endinterface

/* rtl/gbn_datapath.sv */
// Window state (base, next sequence, duplicate count, window size), result
// register and retransmit run counter. Depends on gbn_pkg.
module gbn_datapath (
  input  logic              clk,
  input  logic              rst,
  input  gbn_pkg::dp_cmd_t  cmd,
  output gbn_pkg::dp_stat_t stat,
  input  logic              cfg_wr_en,
  input  gbn_pkg::seq_t     cfg_wr_data,
  input  gbn_pkg::cmd_t     command,
  input  gbn_pkg::seq_t     ack_seq,
  input  logic              ack_valid,
  output gbn_pkg::res_t     res
);
  import gbn_pkg::*;

  seq_t window_size;
  seq_t window_base;
  seq_t next_seq;
  dup_t dup_count;
  seq_t run_seq;

  seq_t outstanding;
  seq_t ack_off;
  seq_t ack_inc;
  dup_t dup_inc;
  logic send_ok;
  logic ack_ok;
  logic dup_ack;
  logic rtx;
  res_t rtx_res;
  res_t first_res;

  always_comb begin
    outstanding = next_seq - window_base;
    ack_off     = ack_seq - window_base;
    ack_inc     = ack_seq + 1'b1;
    dup_inc     = dup_count + 1'b1;
    send_ok     = outstanding < window_size;
    ack_ok      = ack_valid && (ack_off < window_size) && (ack_off < outstanding);
    dup_ack     = ack_valid && !ack_ok && (ack_inc == window_base);
    rtx         = (command == CMD_TIMEOUT) ||
                  ((command == CMD_ACK) && dup_ack && (dup_inc == DUP_LIMIT));

    if (outstanding == '0) begin
      rtx_res = '{kind: KIND_EMPTY, seq: window_base, timer_action: TIMER_STOP,
                  last: 1'b1, all_acked: 1'b1};
    end else begin
      rtx_res = '{kind: KIND_RETX, seq: window_base, timer_action: TIMER_START,
                  last: (outstanding == seq_t'(1)), all_acked: 1'b0};
    end

    first_res = '{kind: KIND_IGNORED, seq: window_base, timer_action: TIMER_NONE,
                  last: 1'b1, all_acked: (outstanding == '0)};
    unique case (command)
      CMD_SEND: begin
        if (send_ok) begin
          first_res = '{kind: KIND_NEW, seq: next_seq,
                        timer_action: (outstanding == '0) ? TIMER_START : TIMER_NONE,
                        last: 1'b1, all_acked: 1'b0};
        end else begin
          first_res.kind = KIND_REFUSED;
        end
      end
      CMD_ACK: begin
        if (ack_ok) begin
          first_res = '{kind: KIND_ACCEPTED, seq: ack_inc,
                        timer_action: (ack_inc == next_seq) ? TIMER_STOP : TIMER_NONE,
                        last: 1'b1, all_acked: (ack_inc == next_seq)};
        end else if (rtx) begin
          first_res = rtx_res;
        end
      end
      CMD_TIMEOUT: first_res = rtx_res;
      default:     first_res = rtx_res;
    endcase

    stat.emit     = (command != CMD_UNUSED);
    stat.more     = rtx && (outstanding > seq_t'(1));
    stat.run_last = (seq_t'(run_seq + 1'b1) == next_seq);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_INIT;
      window_base <= '0;
      next_seq    <= '0;
      dup_count   <= '0;
    end else begin
      if (cfg_wr_en) begin
        window_size <= cfg_wr_data;
      end
      if (cmd.load) begin
        if (command == CMD_SEND && send_ok) begin
          next_seq <= next_seq + 1'b1;
        end
        if (command == CMD_ACK) begin
          if (ack_ok) begin
            window_base <= ack_inc;
          end else if (rtx) begin
            dup_count <= '0;
          end else if (dup_ack) begin
            dup_count <= dup_inc;
          end
        end
      end
    end
  end

  // result payload and run position need no reset
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res     <= first_res;
      run_seq <= window_base + 1'b1;
    end else if (cmd.step) begin
      res     <= '{kind: KIND_RETX, seq: run_seq, timer_action: TIMER_NONE,
                   last: stat.run_last, all_acked: 1'b0};
      run_seq <= run_seq + 1'b1;
    end
  end

  // the count clears as it reaches the limit, so it never rests there
  a_dup_below_limit: assert property (@(posedge clk) disable iff (rst)
    dup_count != DUP_LIMIT)
    else $error("duplicate count resting at limit");

endmodule

/* rtl/gbn_ctrl.sv */
// Sequencing FSM: request acceptance, retransmit run stepping and the
// result register's valid flag. Depends on gbn_pkg.
module gbn_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              res_valid,
  input  logic              res_ready,
  input  gbn_pkg::dp_stat_t stat,
  output gbn_pkg::dp_cmd_t  cmd
);
  import gbn_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state;
  logic state_next;
  logic out_valid;
  logic out_valid_next;
  logic slot_free;
  logic accept;

  always_comb begin
    slot_free = !out_valid || res_ready;
    req_ready = (state == ST_IDLE) && slot_free;
    accept    = req_valid && req_ready;
    cmd.load  = accept;
    cmd.step  = (state == ST_RUN) && slot_free;

    priority if (accept && stat.emit) begin
      out_valid_next = 1'b1;
    end else if (cmd.step) begin
      out_valid_next = 1'b1;
    end else if (res_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end

    state_next = state;
    unique case (state)
      ST_IDLE: if (accept && stat.more) state_next = ST_RUN;
      ST_RUN:  if (cmd.step && stat.run_last) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign res_valid = out_valid;

  a_no_accept_in_run: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> !(req_valid && req_ready))
    else $error("request taken during retransmit run");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && stat.emit) |=> res_valid)
    else $error("accepted transaction produced no result");

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && cmd.step && stat.run_last) |=> (state == ST_IDLE && res_valid))
    else $error("retransmit run did not close");

endmodule

/* rtl/go_back_n_sender_window.sv */
// Go-back-N sender window control with fast retransmit over 4-bit sequence
// numbers (window_size resets to 4). Sends, ACKs and timeouts are taken one
// per cycle, while the result side is ready, when each produces a single result;
// the result sits in an output register, so a new request is taken in the
// same cycle the previous result leaves. A timeout or third duplicate ACK with
// n > 0 numbers outstanding yields a run of n retransmit results, one per
// cycle while the result side is ready, from the datapath's run counter;
// requests are held off until the run's last result is loaded. Command code
// 3 gives no result. Depends on gbn_pkg, gbn_ifs, gbn_ctrl and gbn_datapath.
module go_back_n_sender_window (
  input  logic          clk,
  input  logic          rst,
  gbn_req_if.sink       request,
  gbn_res_if.source     result,
  input  logic          cfg_wr_en,
  input  gbn_pkg::seq_t cfg_wr_data
);
  import gbn_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  res_t     res;

  gbn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_ready (request.ready),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  gbn_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .command     (request.command),
    .ack_seq     (request.ack_seq),
    .ack_valid   (request.ack_valid),
    .res         (res)
  );

  assign result.kind         = res.kind;
  assign result.seq          = res.seq;
  assign result.timer_action = res.timer_action;
  assign result.last         = res.last;
  assign result.all_acked    = res.all_acked;

endmodule

/* tb/go_back_n_sender_window_test.sv */
// Self-checking testbench for go_back_n_sender_window: directed and random
// sends, ACKs and timeouts against an in-bench window model, random stalls.
// Depends on gbn_pkg, gbn_ifs and the go_back_n_sender_window RTL.
`timescale 1ns / 1ps

module go_back_n_sender_window_test;
  import gbn_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  seq_t cfg_wr_data;

  gbn_req_if req ();
  gbn_res_if res ();

  go_back_n_sender_window DUT (
    .clk         (clk),
    .rst         (rst),
    .request     (req),
    .result      (res),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #2 clk = ~clk;

  // window model
  seq_t win_base;
  seq_t next_num;
  dup_t dup_hits;
  seq_t win_size;

  res_t due_results[$];
  res_t fresh[$];

  int   mismatches = 0;
  int   taken = 0;
  int   checked = 0;
  int   longest_run = 0;
  int   cycles = 0;
  logic steady = 1'b0;

  function automatic res_t make_res(kind_t k, seq_t s, timer_t t);
    res_t r;
    r.kind         = k;
    r.seq          = s;
    r.timer_action = t;
    r.last         = 1'b0;
    r.all_acked    = 1'b0;
    return r;
  endfunction

  function automatic void queue_retransmits();
    seq_t outst;
    outst = next_num - win_base;
    if (outst == 0) begin
      fresh.push_back(make_res(KIND_EMPTY, win_base, TIMER_STOP));
    end else begin
      for (int i = 0; i < outst; i++)
        fresh.push_back(make_res(KIND_RETX, seq_t'(win_base + i),
                                 (i == 0) ? TIMER_START : TIMER_NONE));
      if (int'(outst) > longest_run) longest_run = int'(outst);
    end
  endfunction

  function automatic void predict_window_step(cmd_t c, seq_t a, logic v);
    seq_t outst;
    seq_t ack_off;
    logic rerun;
    outst   = next_num - win_base;
    ack_off = a - win_base;
    rerun   = 1'b0;
    fresh.delete();
    case (c)
      CMD_SEND: begin
        if (outst < win_size) begin
          fresh.push_back(make_res(KIND_NEW, next_num,
                                   (outst == 0) ? TIMER_START : TIMER_NONE));
          next_num = next_num + 1'b1;
        end else begin
          fresh.push_back(make_res(KIND_REFUSED, win_base, TIMER_NONE));
        end
      end
      CMD_ACK: begin
        if (v && ack_off < win_size && ack_off < outst) begin
          win_base = a + 1'b1;
          fresh.push_back(make_res(KIND_ACCEPTED, win_base,
                                   (win_base == next_num) ? TIMER_STOP : TIMER_NONE));
        end else begin
          // duplicate count is never cleared by a fresh ACK
          if (v && seq_t'(a + 1'b1) == win_base) begin
            dup_hits = dup_hits + 1'b1;
            if (dup_hits >= DUP_LIMIT) begin
              dup_hits = '0;
              rerun = 1'b1;
            end
          end
          if (rerun) queue_retransmits();
          else fresh.push_back(make_res(KIND_IGNORED, win_base, TIMER_NONE));
        end
      end
      CMD_TIMEOUT: queue_retransmits();
      CMD_UNUSED: ;
      default: ;
    endcase
    foreach (fresh[i]) begin
      fresh[i].all_acked = (win_base == next_num);
      fresh[i].last      = (i == fresh.size() - 1);
      due_results.push_back(fresh[i]);
    end
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [3:0] got, logic [3:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                checked, name, got, want));
  endtask

  // transactions on both channels, predicted and checked in one place
  always @(posedge clk) begin : monitor
    res_t got;
    res_t want;
    if (!rst) begin
      if (req.valid && req.ready) begin
        predict_window_step(req.command, req.ack_seq, req.ack_valid);
        taken++;
      end
      if (res.valid && res.ready) begin
        got = {res.kind, res.seq, res.timer_action, res.last, res.all_acked};
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d seq %0d",
                                    got.kind, got.seq));
        end else begin
          want = due_results.pop_front();
          check_field("kind", 4'(got.kind), 4'(want.kind));
          check_field("seq", got.seq, want.seq);
          check_field("timer_action", 4'(got.timer_action), 4'(want.timer_action));
          check_field("last", 4'(got.last), 4'(want.last));
          check_field("all_acked", 4'(got.all_acked), 4'(want.all_acked));
          checked++;
        end
      end
    end
  end

  always @(posedge clk) begin
    res.ready <= steady || ($urandom_range(99) >= 38);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timed out after %0d cycles, %0d results outstanding",
               cycles, due_results.size());
      $display("go_back_n_sender_window_test: FAIL");
      $finish;
    end
  end

  task automatic send_item(cmd_t c, seq_t a, logic v);
    while (!steady && $urandom_range(99) < 38) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid     <= 1'b1;
    req.command   <= c;
    req.ack_seq   <= a;
    req.ack_valid <= v;
    do @(posedge clk); while (!req.ready);
  endtask

  // hold requests until every expected result is out, then idle
  task automatic drain();
    req.valid <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_window(seq_t w);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    win_size = w;
  endtask

  task automatic test_reset_window();
    send_item(CMD_TIMEOUT, 4'd0, 1'b0);      // nothing outstanding
    send_item(CMD_ACK, 4'd15, 1'b1);         // counts as a duplicate
    send_item(CMD_ACK, 4'd15, 1'b0);         // corrupt, not counted
    repeat (5) send_item(CMD_SEND, 4'd0, 1'b0); // last one refused
    send_item(CMD_ACK, 4'd7, 1'b1);          // beyond the window
    send_item(CMD_ACK, 4'd1, 1'b0);
    send_item(CMD_ACK, 4'd1, 1'b1);          // base moves to 2
    send_item(CMD_ACK, 4'd1, 1'b1);
    send_item(CMD_ACK, 4'd1, 1'b1);          // third duplicate: fast retransmit
    send_item(CMD_TIMEOUT, 4'd9, 1'b1);
    send_item(CMD_UNUSED, 4'd15, 1'b1);
    send_item(CMD_ACK, 4'd3, 1'b1);          // empties the window, timer stop
  endtask

  task automatic test_window_extremes();
    write_window(4'd0);
    send_item(CMD_SEND, 4'd0, 1'b0);
    write_window(4'd1);
    send_item(CMD_SEND, 4'd0, 1'b0);
    send_item(CMD_SEND, 4'd0, 1'b0);
    send_item(CMD_TIMEOUT, 4'd0, 1'b0);
  endtask

  task automatic random_phase(int n);
    int   pick;
    seq_t outst;
    seq_t a;
    logic v;
    for (int k = 0; k < n; k++) begin
      pick  = $urandom_range(99);
      outst = next_num - win_base;
      a     = seq_t'($urandom);
      v     = ($urandom_range(9) != 0);
      if (pick < 45) begin
        send_item(CMD_SEND, a, v);
      end else if (pick < 80) begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4: if (outst != 0) a = seq_t'(win_base + $urandom_range(outst - 1));
          5, 6, 7: a = win_base - 1'b1;
          default: ;
        endcase
        send_item(CMD_ACK, a, v);
      end else if (pick < 92) begin
        send_item(CMD_TIMEOUT, a, v);
      end else begin
        send_item(cmd_t'($urandom_range(3)), a, v);
      end
    end
  endtask

  task automatic test_random();
    write_window(4'd15);
    random_phase(60);
    write_window(4'd1);
    random_phase(40);
    write_window(seq_t'($urandom_range(14, 2)));
    steady = 1'b1;
    random_phase(50);
    steady = 1'b0;
    write_window(WINDOW_INIT);
    random_phase(50);
    drain();
    write_window(4'd15);
    random_phase(50);
  endtask

  initial begin
    win_base  = '0;
    next_num  = '0;
    dup_hits  = '0;
    win_size  = WINDOW_INIT;
    rst           <= 1'b1;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= '0;
    req.valid     <= 1'b0;
    req.command   <= CMD_SEND;
    req.ack_seq   <= '0;
    req.ack_valid <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_window();
    test_window_extremes();
    test_random();
    drain();
    repeat (16) @(posedge clk);
    if (due_results.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", due_results.size()));

    $display("%0d requests taken, %0d results checked; windows 0, 1, 4, 15 and one random",
             taken, checked);
    $display("longest retransmit run %0d, %0d mismatches", longest_run, mismatches);
    if (mismatches == 0) begin
      $display("go_back_n_sender_window_test: PASS");
    end else begin
      $display("go_back_n_sender_window_test: FAIL");
    end
    $finish;
  end

endmodule
